// ===== design/lfce_pkg.sv =====
// Shared types and codes of the LED fade cycle engine.
package lfce_pkg;

   // Transaction codes carried in the action field
   localparam logic [1:0] ACT_SET     = 2'd0;
   localparam logic [1:0] ACT_REFRESH = 2'd1;
   localparam logic [1:0] ACT_CLEAR   = 2'd2;
   localparam logic [1:0] ACT_UNUSED  = 2'd3;

   // Configuration register indexes
   localparam logic CSR_MAX_DURATION = 1'b0;
   localparam logic CSR_MAX_REPEATS  = 1'b1;

   localparam logic [15:0] CYCLES_ENDLESS = 16'hFFFF;
   localparam logic [15:0] MAX_DUR_RESET  = 16'd10000;
   localparam logic [14:0] MAX_REP_RESET  = 15'd100;

   typedef struct packed {
      logic [1:0]         action;
      logic [7:0]         led_index;
      logic [7:0]         peak_level;
      logic [15:0]        fade_duration;
      logic signed [15:0] fade_cycles;
      logic [7:0]         color_red;
      logic [7:0]         color_green;
      logic [7:0]         color_blue;
      logic               use_fade_in;
      logic [31:0]        now_ms;
   } lfce_req_type;

   typedef struct packed {
      logic [7:0] out_index;
      logic [7:0] pixel_red;
      logic [7:0] pixel_green;
      logic [7:0] pixel_blue;
      logic       is_active;
   } lfce_rsp_type;

   // One LED's stored state
   typedef struct packed {
      logic [7:0]  peak;
      logic [15:0] dur;
      logic [15:0] cyc;
      logic [23:0] color;
      logic        fading;
      logic        fade_in;
      logic        ramp_up;
      logic [31:0] start;
      logic [23:0] shown;
   } lfce_entry_type;

   localparam lfce_entry_type ENTRY_DEFAULT = '{
      peak: 8'd0, dur: 16'd0, cyc: 16'd0, color: 24'd0, fading: 1'b0,
      fade_in: 1'b1, ramp_up: 1'b0, start: 32'd0, shown: 24'd0};

   // How the shown pixel is formed
   typedef enum logic [1:0] {
      PIX_KEEP,
      PIX_BLACK,
      PIX_SCALE_PEAK,
      PIX_SCALE_DIV
   } lfce_pix_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_DIV,
      S_SCALE,
      S_WRITE
   } lfce_state_type;

   typedef struct packed {
      logic load;
      logic read;
      logic eval;
      logic div_step;
      logic scale;
      logic write;
   } lfce_cmd_type;

   typedef struct packed {
      logic skip;
      logic is_clear;
      logic need_div;
      logic div_last;
   } lfce_stat_type;

endpackage

// ===== design/lfce_ctrl.sv =====
// Sequencer of the LED fade cycle engine.
module lfce_ctrl import lfce_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  lfce_stat_type stat,
   output lfce_cmd_type  cmd
);

   lfce_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_READ;
         end
         S_READ: begin
            state_in = stat.skip ? S_IDLE : S_EVAL;
         end
         S_EVAL: begin
            if (stat.is_clear)      state_in = S_WRITE;
            else if (stat.need_div) state_in = S_DIV;
            else                    state_in = S_SCALE;
         end
         S_DIV: begin
            if (stat.div_last) state_in = S_SCALE;
         end
         S_SCALE: state_in = S_WRITE;
         S_WRITE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         S_READ:  cmd.read     = !stat.skip;
         S_EVAL:  cmd.eval     = 1'b1;
         S_DIV:   cmd.div_step = 1'b1;
         S_SCALE: cmd.scale    = 1'b1;
         S_WRITE: cmd.write    = 1'b1;
         default: cmd = '0;
      endcase
   end

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start) |=> state_ff == S_READ)
      else $error("accepted transaction did not move to read");
   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && stat.div_last) |=> state_ff == S_SCALE)
      else $error("divider end not followed by scaling");
   a_write_single: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRITE |=> state_ff == S_IDLE)
      else $error("write lasted more than one cycle");

endmodule

// ===== design/lfce_datapath.sv =====
// LED state memory, ramp evaluation, level divider and pixel scaling.
module lfce_datapath import lfce_pkg::*; #(
   parameter int LED_COUNT = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  lfce_req_type req_data,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata,
   input  lfce_cmd_type cmd,
   output lfce_stat_type stat,
   output logic         rsp_valid,
   output lfce_rsp_type rsp_data
);

   localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

   lfce_req_type   item_ff;
   logic [15:0]    max_dur_ff;
   logic [14:0]    max_rep_ff;
   lfce_entry_type mem [LED_COUNT];
   logic           vld_ff [LED_COUNT];
   lfce_entry_type rd_ff;
   logic           rd_vld_ff;
   lfce_entry_type upd_ff, upd_in;
   lfce_pix_type   pix_ff, pix_in;
   logic [23:0]    src_ff, src_in;
   logic [15:0]    rem_ff;
   logic [7:0]     qsh_ff;
   logic [2:0]     cnt_ff;
   logic [23:0]    pixel_ff;
   logic           rsp_valid_ff;
   lfce_rsp_type   rsp_ff;

   logic [IDX_W-1:0] addr;
   lfce_entry_type   ent;
   logic [31:0]      elapsed;
   logic [15:0]      term;
   logic [23:0]      num;
   logic [15:0]      cyc_dec;
   logic             cyc_ok;
   logic [16:0]      div_t;
   logic             div_ge;
   logic [7:0]       lvl;
   logic [23:0]      pix_calc;

   assign addr = item_ff.led_index[IDX_W-1:0];

   function automatic logic [7:0] scale_ch(logic [7:0] c, logic [7:0] s);
      logic [15:0] p;
      p = c * s;
      return p[15:8] + 8'((c != 8'd0) && (s != 8'd0));
   endfunction

   // Configuration registers and item latch
   always_ff @(posedge clock) begin
      if (reset) begin
         max_dur_ff <= MAX_DUR_RESET;
         max_rep_ff <= MAX_REP_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_MAX_DURATION) max_dur_ff <= csr_wdata;
         if (csr_index == CSR_MAX_REPEATS)  max_rep_ff <= csr_wdata[14:0];
      end
      if (cmd.load) item_ff <= req_data;
   end

   assign stat.skip = ({1'b0, item_ff.led_index} >= 9'(LED_COUNT)) ||
                      !(item_ff.action == ACT_SET || item_ff.action == ACT_REFRESH ||
                        item_ff.action == ACT_CLEAR);
   assign stat.is_clear = (item_ff.action == ACT_CLEAR);

   // State memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_ff     <= mem[addr];
         rd_vld_ff <= vld_ff[addr];
      end
      if (cmd.write && !stat.is_clear) mem[addr] <= upd_ff;
   end

   // Valid bits: a clear transaction drops the entry back to its defaults
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LED_COUNT; i++) vld_ff[i] <= 1'b0;
      end else if (cmd.write) begin
         vld_ff[addr] <= !stat.is_clear;
      end
   end

   assign ent = rd_vld_ff ? rd_ff : ENTRY_DEFAULT;

   // Ramp evaluation
   always_comb begin
      elapsed = item_ff.now_ms - ent.start;
      term    = ent.ramp_up ? elapsed[15:0] : 16'(ent.dur - elapsed[15:0]);
      num     = ent.peak * term;
      cyc_dec = ent.cyc - 16'd1;
      cyc_ok  = (!item_ff.fade_cycles[15] && item_ff.fade_cycles != 16'sd0 &&
                 item_ff.fade_cycles[14:0] <= max_rep_ff) ||
                (item_ff.fade_cycles == CYCLES_ENDLESS);
      upd_in  = ent;
      pix_in  = PIX_KEEP;
      src_in  = ent.color;
      if (item_ff.action == ACT_SET) begin
         upd_in.peak = item_ff.peak_level;
         if (item_ff.fade_duration <= max_dur_ff) upd_in.dur = item_ff.fade_duration;
         if (cyc_ok) upd_in.cyc = item_ff.fade_cycles;
         upd_in.color   = {item_ff.color_red, item_ff.color_green, item_ff.color_blue};
         upd_in.fading  = 1'b1;
         upd_in.start   = item_ff.now_ms;
         upd_in.ramp_up = item_ff.use_fade_in;
         upd_in.fade_in = item_ff.use_fade_in;
      end else if (ent.fading) begin
         if (ent.dur != 16'd0 && elapsed < {16'd0, ent.dur}) begin
            pix_in = PIX_SCALE_DIV;
         end else if (ent.ramp_up) begin
            pix_in         = PIX_SCALE_PEAK;
            upd_in.ramp_up = 1'b0;
            upd_in.start   = item_ff.now_ms;
         end else if (ent.cyc != CYCLES_ENDLESS &&
                      (cyc_dec == 16'd0 || cyc_dec[15])) begin
            // last cycle done: stop, keep start time
            upd_in.cyc    = cyc_dec;
            upd_in.fading = 1'b0;
            pix_in        = PIX_BLACK;
         end else begin
            if (ent.cyc != CYCLES_ENDLESS) upd_in.cyc = cyc_dec;
            upd_in.start = item_ff.now_ms;
            if (ent.fade_in) begin
               upd_in.ramp_up = 1'b1;
               pix_in         = PIX_BLACK;
            end else begin
               pix_in = PIX_SCALE_PEAK;
            end
         end
      end else if (ent.cyc != 16'd0) begin
         // restart of a stopped LED
         upd_in.fading  = 1'b1;
         upd_in.ramp_up = ent.fade_in;
         upd_in.start   = item_ff.now_ms;
         src_in         = ent.shown;
         pix_in         = ent.fade_in ? PIX_BLACK : PIX_SCALE_PEAK;
      end
   end

   assign stat.need_div = (pix_in == PIX_SCALE_DIV);

   // Restoring divider, one quotient bit a cycle; quotient fits in 8 bits
   assign div_t  = {rem_ff, qsh_ff[7]};
   assign div_ge = div_t >= {1'b0, upd_ff.dur};
   assign stat.div_last = (cnt_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         upd_ff <= upd_in;
         pix_ff <= pix_in;
         src_ff <= src_in;
         rem_ff <= num[23:8];
         qsh_ff <= num[7:0];
         cnt_ff <= 3'd0;
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? 16'(div_t - {1'b0, upd_ff.dur}) : div_t[15:0];
         qsh_ff <= {qsh_ff[6:0], div_ge};
         cnt_ff <= cnt_ff + 3'd1;
      end else if (cmd.scale) begin
         upd_ff.shown <= pix_calc;
      end
   end

   // Video scaling
   assign lvl = (pix_ff == PIX_SCALE_DIV) ? qsh_ff : upd_ff.peak;

   always_comb begin
      case (pix_ff)
         PIX_KEEP:  pix_calc = upd_ff.shown;
         PIX_BLACK: pix_calc = 24'd0;
         default:   pix_calc = {scale_ch(src_ff[23:16], lvl),
                                scale_ch(src_ff[15:8], lvl),
                                scale_ch(src_ff[7:0], lvl)};
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         pixel_ff <= pix_calc;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.write && (item_ff.action == ACT_REFRESH);
      end
      if (cmd.write) begin
         rsp_ff.out_index   <= item_ff.led_index;
         rsp_ff.pixel_red   <= pixel_ff[23:16];
         rsp_ff.pixel_green <= pixel_ff[15:8];
         rsp_ff.pixel_blue  <= pixel_ff[7:0];
         rsp_ff.is_active   <= upd_ff.fading;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_after_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.write))
      else $error("result without a write");
   a_div_needs_dur: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> upd_ff.dur != 16'd0)
      else $error("division by zero duration");
   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < upd_ff.dur)
      else $error("divider remainder out of range");

endmodule

// ===== design/led_fade_cycle_engine_top.sv =====
// Top level of the LED fade cycle engine.
//  channel  | ports                          | handshake
//  request  | start, busy, req_data          | taken when start high and busy low
//  response | rsp_valid, rsp_data            | one-cycle strobe, no back-pressure
//  config   | csr_we, csr_index, csr_wdata   | written when csr_we high
// A refresh within a ramp passes read, evaluate, 8 divider steps, scale and write; a refresh
// that ends a ramp or restarts and a set skip the divider, a clear goes from evaluate to write,
// an ignored transaction returns to idle after read; none is taken until idle is reached again.
// The 8-step restoring level divider makes a refresh within a ramp the longest transaction.
// Reset is synchronous; LED states return to defaults through per-LED valid bits.
// The receiver cannot stall; busy holds off new transactions while one is at work.
module led_fade_cycle_engine_top import lfce_pkg::*; #(
   parameter int LED_COUNT = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  lfce_req_type req_data,
   output logic         rsp_valid,
   output lfce_rsp_type rsp_data,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);

   lfce_cmd_type  cmd;
   lfce_stat_type stat;

   // Sequencer
   lfce_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Datapath
   lfce_datapath #(.LED_COUNT(LED_COUNT)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== dv/tb_led_fade_cycle_engine_top.sv =====
// Self-checking testbench of the LED fade cycle engine: directed and random transactions.
module tb_led_fade_cycle_engine_top;
   import lfce_pkg::*;

   localparam int LEDS = 128;

   // Predicted behaviour of the fade engine and the queue of expected pixels
   class fade_scoreboard;
      logic [15:0] lim_dur;
      logic [14:0] lim_rep;
      logic [7:0]  peak [LEDS];
      logic [15:0] dur [LEDS];
      logic [15:0] cyc [LEDS];
      logic [23:0] color [LEDS];
      logic        fading [LEDS];
      logic        fade_in [LEDS];
      logic        ramp_up [LEDS];
      logic [31:0] t0 [LEDS];
      logic [23:0] shown [LEDS];
      lfce_rsp_type pending_pixels [$];
      int errors;

      function new();
         lim_dur = MAX_DUR_RESET;
         lim_rep = MAX_REP_RESET;
         errors = 0;
         for (int i = 0; i < LEDS; i++) wipe(i);
      endfunction

      function void wipe(int i);
         peak[i] = 0; dur[i] = 0; cyc[i] = 0; color[i] = 0; fading[i] = 0;
         fade_in[i] = 1; ramp_up[i] = 0; t0[i] = 0; shown[i] = 0;
      endfunction

      function void write_csr(logic idx, logic [15:0] v);
         if (idx == CSR_MAX_DURATION) lim_dur = v;
         else lim_rep = v[14:0];
      endfunction

      function logic [7:0] dim(logic [7:0] c, logic [7:0] s);
         logic [15:0] p;
         p = c * s;
         return p[15:8] + ((c != 0 && s != 0) ? 8'd1 : 8'd0);
      endfunction

      function logic [23:0] dim_rgb(logic [23:0] rgb, logic [7:0] s);
         return {dim(rgb[23:16], s), dim(rgb[15:8], s), dim(rgb[7:0], s)};
      endfunction

      // Advance one LED's ramp at the given time
      function void advance(int i, logic [31:0] now);
         logic [31:0] el;
         logic [39:0] num;
         logic [15:0] c;
         if (fading[i]) begin
            el = now - t0[i];
            if (dur[i] != 0 && el < dur[i]) begin
               num = ramp_up[i] ? peak[i] * el : peak[i] * (dur[i] - el);
               shown[i] = dim_rgb(color[i], 8'(num / dur[i]));
               return;
            end
            if (ramp_up[i]) begin
               shown[i] = dim_rgb(color[i], peak[i]);
               ramp_up[i] = 0;
            end else begin
               if (cyc[i] != CYCLES_ENDLESS) begin
                  c = cyc[i] - 16'd1;
                  cyc[i] = c;
                  if (c == 0 || c[15]) begin
                     shown[i] = 0;
                     fading[i] = 0;
                     return;
                  end
               end
               if (fade_in[i]) begin
                  ramp_up[i] = 1;
                  shown[i] = 0;
               end else shown[i] = dim_rgb(color[i], peak[i]);
            end
            t0[i] = now;
         end else if (cyc[i] != 0) begin
            fading[i] = 1;
            ramp_up[i] = fade_in[i];
            t0[i] = now;
            shown[i] = ramp_up[i] ? 24'd0 : dim_rgb(shown[i], peak[i]);
         end
      endfunction

      // Note an accepted transaction
      function void note_request(lfce_req_type r);
         int i;
         lfce_rsp_type e;
         i = r.led_index;
         if (r.led_index >= LEDS) return;
         case (r.action)
            ACT_SET: begin
               peak[i] = r.peak_level;
               if (r.fade_duration <= lim_dur) dur[i] = r.fade_duration;
               if ((!r.fade_cycles[15] && r.fade_cycles != 0 &&
                    r.fade_cycles[14:0] <= lim_rep) || r.fade_cycles == CYCLES_ENDLESS)
                  cyc[i] = r.fade_cycles;
               color[i] = {r.color_red, r.color_green, r.color_blue};
               fading[i] = 1;
               t0[i] = r.now_ms;
               ramp_up[i] = r.use_fade_in;
               fade_in[i] = r.use_fade_in;
            end
            ACT_CLEAR: wipe(i);
            ACT_REFRESH: begin
               advance(i, r.now_ms);
               e.out_index = r.led_index;
               {e.pixel_red, e.pixel_green, e.pixel_blue} = shown[i];
               e.is_active = fading[i];
               pending_pixels.push_back(e);
            end
            default: ;
         endcase
      endfunction

      // Compare one strobed pixel with the oldest expectation
      function void check_pixel(lfce_rsp_type a);
         lfce_rsp_type e;
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, actual %h", $time, a);
            errors++;
            return;
         end
         e = pending_pixels.pop_front();
         if (a.out_index != e.out_index || a.pixel_red != e.pixel_red ||
             a.pixel_green != e.pixel_green || a.pixel_blue != e.pixel_blue ||
             a.is_active != e.is_active) begin
            $display("%0t: pixel mismatch, expected %h, actual %h", $time, e, a);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   lfce_req_type req_data = '0;
   logic rsp_valid;
   lfce_rsp_type rsp_data;
   logic csr_we = 0;
   logic csr_index = 0;
   logic [15:0] csr_wdata = 0;

   fade_scoreboard sb = new();
   logic [31:0] clock_ms = 0;

   always #1 clock = ~clock;

   led_fade_cycle_engine_top #(.LED_COUNT(LEDS)) u_dut (.*);

   // Result monitor
   always @(posedge clock)
      if (!reset && rsp_valid) sb.check_pixel(rsp_data);

   // Issue one transaction after a random gap; start stays high into a zero gap
   task automatic issue(lfce_req_type r);
      int gap;
      gap = $urandom_range(0, 9);
      if (gap != 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic drain();
      start <= 0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] v);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      sb.write_csr(idx, v);
      @(posedge clock);
   endtask

   function automatic lfce_req_type rand_req(logic [1:0] act, int idx_hi);
      lfce_req_type r;
      r.action = act;
      r.led_index = 8'($urandom_range(0, idx_hi));
      r.peak_level = 8'($urandom);
      case ($urandom_range(0, 3))
         0: r.fade_duration = 16'($urandom_range(0, 3));
         1: r.fade_duration = 16'($urandom);
         default: r.fade_duration = 16'($urandom_range(0, 400));
      endcase
      case ($urandom_range(0, 4))
         0: r.fade_cycles = -16'sd1;
         1: r.fade_cycles = 16'($urandom);
         default: r.fade_cycles = 16'($urandom_range(0, 4));
      endcase
      r.color_red = 8'($urandom);
      r.color_green = 8'($urandom);
      r.color_blue = 8'($urandom);
      r.use_fade_in = 1'($urandom);
      r.now_ms = clock_ms;
      return r;
   endfunction

   function automatic lfce_req_type mk(logic [1:0] act, logic [7:0] idx, logic [7:0] pk,
                                       logic [15:0] d, logic [15:0] c, logic [23:0] rgb,
                                       logic fi, logic [31:0] t);
      lfce_req_type r;
      r.action = act; r.led_index = idx; r.peak_level = pk; r.fade_duration = d;
      r.fade_cycles = c; {r.color_red, r.color_green, r.color_blue} = rgb;
      r.use_fade_in = fi; r.now_ms = t;
      return r;
   endfunction

   initial begin
      lfce_req_type r;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, ignored items, invalid fields, zero duration, wrap
      issue(mk(ACT_REFRESH, 0, 0, 0, 0, 0, 0, 0));
      issue(mk(ACT_SET, 127, 255, 100, 2, 24'hFFFFFF, 1, 32'hFFFF_FFF0));
      issue(mk(ACT_REFRESH, 127, 0, 0, 0, 0, 0, 32'h0000_0020));
      issue(mk(ACT_REFRESH, 127, 0, 0, 0, 0, 0, 32'h0000_0070));
      issue(mk(ACT_REFRESH, 127, 0, 0, 0, 0, 0, 32'h0000_00F0));
      issue(mk(ACT_REFRESH, 127, 0, 0, 0, 0, 0, 32'h0000_0200));
      issue(mk(ACT_SET, 128, 255, 5, 3, 24'h0102FF, 0, 0));
      issue(mk(ACT_REFRESH, 255, 0, 0, 0, 0, 0, 0));
      issue(mk(ACT_UNUSED, 1, 0, 0, 0, 0, 0, 0));
      issue(mk(ACT_SET, 1, 128, 65535, 16'h7FFF, 24'h010101, 0, 5));
      issue(mk(ACT_REFRESH, 1, 0, 0, 0, 0, 0, 6));
      issue(mk(ACT_SET, 2, 200, 0, 1, 24'h80FF01, 0, 0));
      issue(mk(ACT_REFRESH, 2, 0, 0, 0, 0, 0, 0));
      issue(mk(ACT_REFRESH, 2, 0, 0, 0, 0, 0, 0));
      issue(mk(ACT_SET, 3, 77, 0, 16'hFFFF, 24'h00FF00, 1, 9));
      issue(mk(ACT_REFRESH, 3, 0, 0, 0, 0, 0, 9));
      issue(mk(ACT_REFRESH, 3, 0, 0, 0, 0, 0, 9));
      issue(mk(ACT_CLEAR, 3, 0, 0, 0, 0, 0, 0));
      issue(mk(ACT_REFRESH, 3, 0, 0, 0, 0, 0, 0));
      issue(mk(ACT_SET, 4, 255, 10000, 16'h8000, 24'hFFFFFF, 1, 0));
      issue(mk(ACT_REFRESH, 4, 0, 0, 0, 0, 0, 5000));
      drain();

      // Random phases over several limit settings
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin write_reg(CSR_MAX_DURATION, 16'd300); write_reg(CSR_MAX_REPEATS, 16'd3); end
            1: begin write_reg(CSR_MAX_DURATION, 16'd0); write_reg(CSR_MAX_REPEATS, 16'd1); end
            2: begin write_reg(CSR_MAX_DURATION, 16'hFFFF);
                     write_reg(CSR_MAX_REPEATS, 16'h7FFF); end
            3: begin write_reg(CSR_MAX_DURATION, 16'($urandom));
                     write_reg(CSR_MAX_REPEATS, 16'($urandom_range(1, 32767))); end
            default: begin write_reg(CSR_MAX_DURATION, 16'd50);
                           write_reg(CSR_MAX_REPEATS, 16'd2); end
         endcase
         for (int n = 0; n < 265; n++) begin
            int pick;
            pick = $urandom_range(0, 99);
            clock_ms += ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 60);
            if (pick < 15) r = rand_req(ACT_SET, 7);
            else if (pick < 85) r = rand_req(ACT_REFRESH, 7);
            else if (pick < 90) r = rand_req(ACT_CLEAR, 7);
            else r = rand_req(2'($urandom), 255);
            issue(r);
            if (n == 130) drain();
         end
         drain();
      end

      if (sb.errors == 0 && sb.pending_pixels.size() == 0)
         $display("led_fade_cycle_engine_top: match");
      else
         $display("led_fade_cycle_engine_top: mismatch");
      $finish;
   end

   // Watchdog
   initial begin
      #400000;
      $display("led_fade_cycle_engine_top: mismatch");
      $finish;
   end
endmodule

// ===== filelist.f =====
design/lfce_pkg.sv
design/lfce_ctrl.sv
design/lfce_datapath.sv
design/led_fade_cycle_engine_top.sv
dv/tb_led_fade_cycle_engine_top.sv
